// ===== rtl/pwlti_pkg.sv =====
// ----------------------------------------------------------------------------
// pwlti_pkg: shared types and constants of the interpolation table
// Request and result structs, command and status codes, and the widths
// used by the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pwlti_pkg;

	// Field widths of the external interface.
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned IDX_W  = 5;
	localparam int unsigned PTS_W  = 6;
	localparam int unsigned STAT_W = 2;

	// Serial divider: quotient magnitude width and step counter width.
	localparam int unsigned QUO_W = 2 * VAL_W;
	localparam int unsigned CNT_W = $clog2(QUO_W);

	// Command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_INTERP     = 2'd0;
	localparam logic [STAT_W-1:0] ST_CLAMP_LO   = 2'd1;
	localparam logic [STAT_W-1:0] ST_CLAMP_HI   = 2'd2;
	localparam logic [STAT_W-1:0] ST_TOO_FEW    = 2'd3;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        entry_index;
		logic signed [VAL_W-1:0] entry_x;
		logic signed [VAL_W-1:0] entry_y;
		logic signed [VAL_W-1:0] query_x;
	} pwlti_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] y_result;
		logic [STAT_W-1:0]       status;
	} pwlti_out_t;

endpackage

`default_nettype wire

// ===== rtl/pwlti_ram.sv =====
// ----------------------------------------------------------------------------
// pwlti_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwlti_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_table_interp_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit: breakpoint table with linear lookup
// Stores up to MAX_POINTS (x, y) breakpoints and answers queries by
// piecewise-linear interpolation with a scan and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
// The in channel carries requests. A load request (cmd = 0) writes one
// breakpoint pair in its accept cycle and returns no result. A query request
// (cmd = 1) returns one result on the out channel: the interpolated or clamped
// y with a status code. The point count is written through cfg_wdata with
// cfg_we; the user writes it only while the unit is idle, the block does not enforce it.
// A query reads entry 0 and the last entry to find the table direction, then
// scans one breakpoint per cycle through the table RAM read port. An
// interior hit between distinct x values then passes through a multiply
// state, a divider setup state, the restoring divider and a final state
// to add and saturate. With fewer than two points a query goes straight
// to its result, and a first-point clamp ends after the direction check.
// A load leaves the sequencer idle, so it does not hold back the next request.
// in_ready is high only while the sequencer is idle; one query is worked on
// at a time. The result sits in an output register, so a stalled receiver
// does not block loads, but a finished query waits for that register.
// Reset clears the point count and the handshake state; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interp_unit #(
	parameter int unsigned MAX_POINTS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire pwlti_pkg::pwlti_in_t        in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output pwlti_pkg::pwlti_out_t            out_data,
	input  wire logic                        cfg_we,
	input  wire logic [pwlti_pkg::PTS_W-1:0] cfg_wdata
);

	import pwlti_pkg::*;

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned NW = $clog2(MAX_POINTS + 1);
	localparam int unsigned DW = VAL_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RD1, S_CHK0, S_SCAN, S_MUL, S_DINIT, S_DIV, S_FIN, S_DONE
	} state_t;

	state_t                  state_q;
	logic [PTS_W-1:0]        points_q;
	logic                    out_valid_q;
	pwlti_out_t              out_q;
	pwlti_out_t              res_q;

	logic [AW-1:0]           addr_q;
	logic [AW-1:0]           idx_q;
	logic [AW-1:0]           last_q;
	logic signed [VAL_W-1:0] q_q;
	logic signed [VAL_W-1:0] prev_x_q;
	logic signed [VAL_W-1:0] prev_y_q;
	logic                    asc_q;

	logic signed [DW-1:0]    dy_q;
	logic signed [DW-1:0]    dx_q;
	logic signed [DW-1:0]    span_q;
	logic signed [2*DW-1:0]  prod_q;

	logic [QUO_W-1:0]        quo_q;
	logic [VAL_W-1:0]        rem_q;
	logic [VAL_W-1:0]        den_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [2*VAL_W-1:0]      ram_wdata;
	logic [2*VAL_W-1:0]      ram_rdata;

	logic signed [VAL_W-1:0] rd_x;
	logic signed [VAL_W-1:0] rd_y;
	logic [NW-1:0]           n_pts;
	logic                    in_fire;
	logic                    asc_now;
	logic                    hit0;
	logic                    hit;
	logic [VAL_W:0]          trial;
	logic [VAL_W+1:0]        diff;
	logic                    ge;
	logic signed [QUO_W:0]   squo;
	logic signed [QUO_W+1:0] sum;
	logic signed [VAL_W-1:0] sat_y;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Table RAM holds {x, y}; loads write only in the accept cycle.
	assign ram_we    = in_fire && (in_data.cmd == CMD_LOAD) &&
		(32'(in_data.entry_index) < 32'(MAX_POINTS));
	assign ram_waddr = AW'(in_data.entry_index);
	assign ram_wdata = {in_data.entry_x, in_data.entry_y};

	pwlti_ram #(
		.WIDTH(2 * VAL_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	assign rd_x = ram_rdata[2*VAL_W-1:VAL_W];
	assign rd_y = ram_rdata[VAL_W-1:0];

	// Effective point count, saturated to the table depth.
	always_comb begin
		if (32'(points_q) > 32'(MAX_POINTS)) begin
			n_pts = NW'(MAX_POINTS);
		end else begin
			n_pts = NW'(points_q);
		end
	end

	// Direction and hit compares for the scan.
	assign asc_now = prev_x_q < rd_x;
	assign hit0    = asc_now ? (q_q <= prev_x_q) : (q_q >= prev_x_q);
	assign hit     = asc_q ? (q_q <= rd_x) : (q_q >= rd_x);

	// One restoring divide step on magnitudes.
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[VAL_W+1];

	// Signed quotient added to the lower y, then saturated.
	assign squo = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum  = (QUO_W+2)'(prev_y_q) + (QUO_W+2)'(squo);
	always_comb begin
		if (sum > (QUO_W+2)'(32767)) begin
			sat_y = 16'sd32767;
		end else if (sum < -(QUO_W+2)'(32768)) begin
			sat_y = -16'sd32768;
		end else begin
			sat_y = sum[VAL_W-1:0];
		end
	end

	// Sequencer, datapath registers and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			points_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				points_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (in_data.cmd == CMD_QUERY)) begin
						q_q    <= in_data.query_x;
						last_q <= AW'(n_pts - 1'b1);
						addr_q <= '0;
						if (n_pts < NW'(2)) begin
							res_q.y_result <= '0;
							res_q.status   <= ST_TOO_FEW;
							state_q        <= S_DONE;
						end else begin
							state_q <= S_RD0;
						end
					end
				end
				S_RD0: begin
					addr_q  <= last_q;
					state_q <= S_RD1;
				end
				S_RD1: begin
					prev_x_q <= rd_x;
					prev_y_q <= rd_y;
					addr_q   <= AW'(1);
					state_q  <= S_CHK0;
				end
				S_CHK0: begin
					// Read data is the last entry here.
					asc_q  <= asc_now;
					idx_q  <= AW'(1);
					addr_q <= AW'(2);
					if (hit0) begin
						res_q.y_result <= prev_y_q;
						res_q.status   <= ST_CLAMP_LO;
						state_q        <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						dy_q   <= DW'(rd_y) - DW'(prev_y_q);
						dx_q   <= DW'(q_q) - DW'(prev_x_q);
						span_q <= DW'(rd_x) - DW'(prev_x_q);
						if (rd_x == prev_x_q) begin
							res_q.y_result <= prev_y_q;
							res_q.status   <= ST_INTERP;
							state_q        <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end else if (idx_q == last_q) begin
						res_q.y_result <= rd_y;
						res_q.status   <= ST_CLAMP_HI;
						state_q        <= S_DONE;
					end else begin
						prev_x_q <= rd_x;
						prev_y_q <= rd_y;
						idx_q    <= idx_q + 1'b1;
						addr_q   <= addr_q + 1'b1;
					end
				end
				S_MUL: begin
					prod_q  <= dy_q * dx_q;
					state_q <= S_DINIT;
				end
				S_DINIT: begin
					neg_q   <= prod_q[2*DW-1] ^ span_q[DW-1];
					quo_q   <= prod_q[2*DW-1] ? QUO_W'(-prod_q) : prod_q[QUO_W-1:0];
					den_q   <= span_q[DW-1] ? VAL_W'(-span_q) : span_q[VAL_W-1:0];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q.y_result <= sat_y;
					res_q.status   <= ST_INTERP;
					state_q        <= S_DONE;
				end
				S_DONE: begin
					// Hand the result over once the output register is free.
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the breakpoint interpolation table
// Loads breakpoint tables of every shape, sets the point count between
// phases, and sends queries under several idle and stall patterns. Each
// result is compared with a local prediction of the lookup.
// ----------------------------------------------------------------------------
module tb_top;
	import pwlti_pkg::*;

	localparam int TABLE_DEPTH  = 32;
	localparam int DRAIN_CYCLES = 80;
	localparam int QUIET_LIMIT  = 4000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	pwlti_in_t  in_data;
	logic       out_valid;
	logic       out_ready;
	pwlti_out_t out_data;
	logic       cfg_we;
	logic [PTS_W-1:0] cfg_wdata;

	// Predicted state of the block.
	logic signed [VAL_W-1:0] bp_x [TABLE_DEPTH];
	logic signed [VAL_W-1:0] bp_y [TABLE_DEPTH];
	logic [PTS_W-1:0]        point_count;
	pwlti_out_t              pending_results[$];

	// Traffic shaping and bookkeeping.
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned hold_req;
	int          mismatches;
	int          items_sent;
	int          n_loads;
	int          n_queries;
	int          n_cfg_writes;
	int          st_seen [4];
	int          quiet_cycles;
	pwlti_out_t  want;
	pwlti_out_t  got;

	piecewise_linear_table_interp_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Expected lookup result for a query against the current table.
	function automatic pwlti_out_t interp_lookup(input logic signed [VAL_W-1:0] q);
		pwlti_out_t r;
		int         n;
		bit         up;
		bit         hit;
		longint     span;
		longint     num;
		longint     yv;
		r.y_result = '0;
		r.status   = ST_TOO_FEW;
		n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
		if (n < 2)
			return r;
		up = bp_x[0] < bp_x[n-1];
		for (int i = 0; i < n; i++) begin
			hit = up ? (q <= bp_x[i]) : (q >= bp_x[i]);
			if (hit) begin
				if (i == 0) begin
					r.y_result = bp_y[0];
					r.status   = ST_CLAMP_LO;
					return r;
				end
				r.status = ST_INTERP;
				span = longint'(bp_x[i]) - longint'(bp_x[i-1]);
				if (span == 0) begin
					r.y_result = bp_y[i-1];
					return r;
				end
				num = (longint'(bp_y[i]) - longint'(bp_y[i-1])) *
				      (longint'(q) - longint'(bp_x[i-1]));
				yv = longint'(bp_y[i-1]) + num / span;
				if (yv > 32767)
					yv = 32767;
				else if (yv < -32768)
					yv = -32768;
				r.y_result = yv[VAL_W-1:0];
				return r;
			end
		end
		r.y_result = bp_y[n-1];
		r.status   = ST_CLAMP_HI;
		return r;
	endfunction

	// A load request; the unused query field carries random bits.
	function automatic pwlti_in_t make_load(input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] xv, input logic signed [VAL_W-1:0] yv);
		pwlti_in_t r;
		r.cmd         = CMD_LOAD;
		r.entry_index = idx;
		r.entry_x     = xv;
		r.entry_y     = yv;
		r.query_x     = 16'($urandom);
		return r;
	endfunction

	// A query request; the unused load fields carry random bits.
	function automatic pwlti_in_t make_query(input logic signed [VAL_W-1:0] q);
		pwlti_in_t r;
		r.cmd         = CMD_QUERY;
		r.entry_index = IDX_W'($urandom);
		r.entry_x     = 16'($urandom);
		r.entry_y     = 16'($urandom);
		r.query_x     = q;
		return r;
	endfunction

	// Query value aimed at the active breakpoints: exact hits, points inside
	// a segment, the range ends, or anything at all.
	function automatic logic signed [VAL_W-1:0] pick_query_x();
		int n;
		int i;
		int lo;
		int hi;
		int sel;
		int tmp;
		n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
		sel = $urandom_range(0, 99);
		if (n < 2 || sel < 25)
			return 16'($urandom);
		if (sel < 35)
			return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		i = $urandom_range(0, n - 2);
		if (sel < 60)
			return bp_x[i + int'($urandom_range(0, 1))];
		lo = int'(bp_x[i]);
		hi = int'(bp_x[i+1]);
		if (lo > hi) begin
			tmp = lo;
			lo  = hi;
			hi  = tmp;
		end
		return 16'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	// Offer one request, wait for its acceptance and update the prediction.
	task automatic send_request(input pwlti_in_t req);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
		if (req.cmd == CMD_LOAD) begin
			bp_x[req.entry_index] = req.entry_x;
			bp_y[req.entry_index] = req.entry_y;
			n_loads++;
		end else begin
			pending_results.push_back(interp_lookup(req.query_x));
			n_queries++;
		end
	endtask

	// Stop offering and wait until every expected result has been taken.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Point count write, only once the block has gone idle.
	task automatic set_point_count(input logic [PTS_W-1:0] cnt);
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		point_count = cnt;
		n_cfg_writes++;
	endtask

	// One table shape: pick a count, load a shaped table, then query it.
	task automatic run_table_round(input int n_q);
		int sel;
		int cnt;
		int ne;
		int shape;
		int cur;
		int step;
		int maxstep;
		logic signed [VAL_W-1:0] xv;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			cnt = $urandom_range(0, 1);
		else if (sel < 20)
			cnt = $urandom_range(TABLE_DEPTH + 1, 63);
		else
			cnt = $urandom_range(2, TABLE_DEPTH);
		set_point_count(PTS_W'(cnt));
		ne = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
		shape = $urandom_range(0, 9);
		cur = -32768 + int'($urandom_range(0, 3000));
		maxstep = (ne > 1) ? 64000 / ne : 1;
		// Shapes 0-3 ascend, 4-7 descend, 8-9 are unordered.
		for (int k = 0; k < ne; k++) begin
			if (shape < 8) begin
				xv = 16'(cur);
				if (shape >= 4)
					xv = ~xv;
				step = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, maxstep));
				cur = (cur + step > 32767) ? 32767 : cur + step;
			end else begin
				xv = 16'($urandom);
			end
			send_request(make_load(IDX_W'(k), xv, 16'($urandom)));
		end
		// Queries, with a stray load now and then.
		for (int k = 0; k < n_q; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_request(make_load(IDX_W'($urandom), 16'($urandom), 16'($urandom)));
			else
				send_request(make_query(pick_query_x()));
		end
	endtask

	// Hand-picked tables: too few points, both clamps, exact breakpoints,
	// full-range spans in both directions and equal end points.
	task automatic test_directed_cases();
		gap_pct   = 0;
		stall_pct = 0;
		send_request(make_load(5'd0, 16'sh8000, 16'sh7FFF));
		send_request(make_load(5'd1, -16'sd100, 16'sd0));
		send_request(make_load(5'd2, -16'sd100, 16'sd500));
		send_request(make_load(5'd3, 16'sh7FFF, 16'sh8000));
		set_point_count(6'd0);
		send_request(make_query(16'sd0));
		set_point_count(6'd1);
		send_request(make_query(16'sd12));
		set_point_count(6'd4);
		send_request(make_query(16'sh8000));
		send_request(make_query(-16'sd200));
		send_request(make_query(-16'sd100));
		send_request(make_query(16'sd0));
		send_request(make_query(16'sh7FFF));
		// Descending table, including a clamp past the last point.
		send_request(make_load(5'd0, 16'sh7FFF, 16'sh8000));
		send_request(make_load(5'd1, 16'sd1000, 16'sh7FFF));
		send_request(make_load(5'd2, 16'sd0, 16'sd7));
		send_request(make_load(5'd3, -16'sd1000, -16'sd1));
		send_request(make_query(16'sh7FFF));
		send_request(make_query(16'sd5000));
		send_request(make_query(16'sd0));
		send_request(make_query(-16'sd1));
		send_request(make_query(16'sh8000));
		// Equal end points count as a descending table.
		send_request(make_load(5'd0, 16'sd300, -16'sd7));
		send_request(make_load(5'd1, 16'sd300, 16'sd9));
		set_point_count(6'd2);
		send_request(make_query(16'sd300));
		send_request(make_query(16'sd299));
	endtask

	// Write every table entry so that any point count is legal afterward.
	task automatic test_table_fill();
		for (int k = 0; k < TABLE_DEPTH; k++)
			send_request(make_load(IDX_W'(k), 16'($urandom), 16'($urandom)));
	endtask

	// Random tables and queries under one idle and stall pattern.
	task automatic test_random_tables(input int unsigned gap, input int unsigned stall,
			input int n_items);
		int stop_at;
		gap_pct   = gap;
		stall_pct = stall;
		stop_at   = items_sent + n_items;
		while (items_sent < stop_at)
			run_table_round($urandom_range(10, 40));
	endtask

	// Receiver holds off while queries keep coming, so the output register
	// fills and the input stalls; then the sender waits for a full drain.
	task automatic test_output_backpressure();
		gap_pct   = 0;
		stall_pct = 0;
		set_point_count(6'd63);
		hold_req = 300;
		for (int k = 0; k < 20; k++) begin
			if (k % 5 == 4)
				send_request(make_load(IDX_W'($urandom), 16'($urandom), 16'($urandom)));
			else
				send_request(make_query(pick_query_x()));
		end
		wait_for_drain();
		for (int k = 0; k < 20; k++)
			send_request(make_query(pick_query_x()));
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		int unsigned hold;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold     = hold_req;
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Result checker: handshake values are stable at the falling edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = out_data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result y_result %0d status %0d",
					$time, got.y_result, got.status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				st_seen[got.status]++;
				if (got.y_result !== want.y_result) begin
					$display("%0t: y_result expected %0d, got %0d",
						$time, want.y_result, got.y_result);
					mismatches++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, got.status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too long without any accepted request or result.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		point_count  = '0;
		gap_pct      = 0;
		stall_pct    = 0;
		hold_req     = 0;
		mismatches   = 0;
		items_sent   = 0;
		n_loads      = 0;
		n_queries    = 0;
		n_cfg_writes = 0;
		quiet_cycles = 0;
		foreach (st_seen[i])
			st_seen[i] = 0;
		foreach (bp_x[i]) begin
			bp_x[i] = '0;
			bp_y[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_fill();
		test_random_tables(0, 0, 360);
		test_random_tables(54, 0, 360);
		test_random_tables(0, 54, 360);
		test_random_tables(21, 21, 360);
		test_output_backpressure();

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d loads and %0d queries over %0d point count settings.",
			n_loads, n_queries, n_cfg_writes);
		$display("Results: %0d interpolated, %0d clamped first, %0d clamped last, %0d too few.",
			st_seen[ST_INTERP], st_seen[ST_CLAMP_LO], st_seen[ST_CLAMP_HI],
			st_seen[ST_TOO_FEW]);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pwlti_pkg.sv
rtl/pwlti_ram.sv
rtl/piecewise_linear_table_interp_unit.sv
tb/tb_top.sv
